// ===== hw/rtl/triangle_face_normal_core_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle face normal core: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_CORE_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_CORE_MACROS_SVH

// same-cycle implication
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define TFN_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal package
// Shared constants and the sideband tag that travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int OUT_W = 32;

    typedef struct packed {
        logic valid;
        logic neg;
        logic degen;
    } tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfn_lane.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal: per-component scaling lane
// Pipelined restoring divide of c^2 * 2^(2F+2) by |c|^2, then pipelined
// integer square root, then round to nearest and apply the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_lane #(
    parameter int NUM_W     = 132,
    parameter int DEN_W     = 134,
    parameter int FRAC_BITS = 30
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tfn_pkg::tag_t                     in_tag,
    input  wire logic [NUM_W-1:0]                  num,
    input  wire logic [DEN_W-1:0]                  den,
    output tfn_pkg::tag_t                          out_tag,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal
);

    localparam int QW   = 2 * FRAC_BITS + 3;   // quotient bits, one per divide stage
    localparam int RTW  = FRAC_BITS + 2;       // root bits, one per sqrt stage
    localparam int RADW = 2 * RTW;
    localparam int REMW = RTW + 2;

    // divide stages
    logic [DEN_W-1:0]  drem_reg [QW];
    logic [DEN_W-1:0]  dden_reg [QW];
    logic [QW-1:0]     dquo_reg [QW];
    tfn_pkg::tag_t     dtag_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_div
        logic [DEN_W:0]    rin;
        logic [DEN_W-1:0]  dcur;
        logic [QW-1:0]     qin;
        tfn_pkg::tag_t     tin;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign rin  = (DEN_W + 1)'(num);
            assign dcur = den;
            assign qin  = '0;
            assign tin  = in_tag;
        end
        else begin : g_rest
            assign rin  = {drem_reg[i-1], 1'b0};
            assign dcur = dden_reg[i-1];
            assign qin  = dquo_reg[i-1];
            assign tin  = dtag_reg[i-1];
        end

        always_comb
        begin
            diff     = rin - {1'b0, dcur};
            ge       = (rin >= {1'b0, dcur});
            rem_next = ge ? diff[DEN_W-1:0] : rin[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            drem_reg[i] <= rem_next;
            dden_reg[i] <= dcur;
            dquo_reg[i] <= {qin[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dtag_reg[i] <= '0;
            end
            else
            begin
                dtag_reg[i] <= tin;
            end
        end
    end

    // square root stages
    logic [RADW-1:0]   srad_reg  [RTW];
    logic [RTW-1:0]    sroot_reg [RTW];
    logic [REMW-1:0]   srem_reg  [RTW];
    tfn_pkg::tag_t     stag_reg  [RTW];

    for (genvar j = 0; j < RTW; j++) begin : g_sqrt
        logic [RADW-1:0]   rad_in;
        logic [RTW-1:0]    root_in;
        logic [REMW-1:0]   rem_in;
        tfn_pkg::tag_t     tin;
        logic [REMW+1:0]   ext;
        logic [REMW+1:0]   trial;
        logic [REMW+1:0]   diff;
        logic              ge;

        if (j == 0) begin : g_first
            assign rad_in  = RADW'(dquo_reg[QW-1]);
            assign root_in = '0;
            assign rem_in  = '0;
            assign tin     = dtag_reg[QW-1];
        end
        else begin : g_rest
            assign rad_in  = srad_reg[j-1];
            assign root_in = sroot_reg[j-1];
            assign rem_in  = srem_reg[j-1];
            assign tin     = stag_reg[j-1];
        end

        always_comb
        begin
            ext   = {rem_in, rad_in[RADW-1 -: 2]};
            trial = (REMW + 2)'({root_in, 2'b01});
            diff  = ext - trial;
            ge    = (ext >= trial);
        end

        always_ff @(posedge clk)
        begin
            srad_reg[j]  <= {rad_in[RADW-3:0], 2'b00};
            sroot_reg[j] <= {root_in[RTW-2:0], ge};
            srem_reg[j]  <= ge ? diff[REMW-1:0] : ext[REMW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stag_reg[j] <= '0;
            end
            else
            begin
                stag_reg[j] <= tin;
            end
        end
    end

    // round: q = floor((n + 1) / 2), then sign; zero when degenerate
    logic [RTW:0]                      nsum;
    logic signed [tfn_pkg::OUT_W-1:0]  qs;
    logic signed [tfn_pkg::OUT_W-1:0]  normal_next;
    logic signed [tfn_pkg::OUT_W-1:0]  normal_reg;
    tfn_pkg::tag_t                     otag_reg;

    always_comb
    begin
        nsum = {1'b0, sroot_reg[RTW-1]} + 1'b1;
        qs   = tfn_pkg::OUT_W'(nsum[RTW:1]);
        if (stag_reg[RTW-1].degen)
        begin
            normal_next = '0;
        end
        else if (stag_reg[RTW-1].neg)
        begin
            normal_next = -qs;
        end
        else
        begin
            normal_next = qs;
        end
    end

    always_ff @(posedge clk)
    begin
        normal_reg <= normal_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            otag_reg <= '0;
        end
        else
        begin
            otag_reg <= stag_reg[RTW-1];
        end
    end

    assign normal  = normal_reg;
    assign out_tag = otag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_face_normal_core.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal core
// Unit normal of a triangle: cross product of its edges, scaled to unit length.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, every stage advances each clock.
// The depth is set by the front stages, the per-component divider (one quotient bit per stage),
// the square root (one root bit per stage) and the output register.
// Reset: rst_n asynchronous, clears all valid bits; no item is in flight after it.
// The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none

module triangle_face_normal_core #(
    parameter int COORD_BITS       = 32,
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [31:0]                p0_x,
    input  wire logic signed [31:0]                p0_y,
    input  wire logic signed [31:0]                p0_z,
    input  wire logic signed [31:0]                p1_x,
    input  wire logic signed [31:0]                p1_y,
    input  wire logic signed [31:0]                p1_z,
    input  wire logic signed [31:0]                p2_x,
    input  wire logic signed [31:0]                p2_y,
    input  wire logic signed [31:0]                p2_z,
    output logic                                   done,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal_x,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal_y,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal_z,
    output logic                                   degenerate
);

    `include "triangle_face_normal_core_macros.svh"

    localparam int N    = COORD_BITS;
    localparam int EW   = N + 1;             // edge width
    localparam int PW   = 2 * EW;            // edge product width
    localparam int CW   = PW + 1;            // cross component width (signed)
    localparam int MW   = CW - 1;            // |c| width
    localparam int NL   = 3;                 // limbs per squaring
    localparam int LB   = (MW + NL - 1) / NL;
    localparam int MP   = NL * LB;
    localparam int SQP  = 2 * MP;
    localparam int SQW  = 2 * MW;            // |c|^2 width
    localparam int SW   = SQW + 2;           // sum of three squares
    localparam int LAT  = 8 + (2 * NORMAL_FRAC_BITS + 3) + (NORMAL_FRAC_BITS + 2) + 1;

    // no back-pressure anywhere: an item can enter every cycle
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // coordinate views: only the low COORD_BITS bits count
    logic [N-1:0] pa [3];
    logic [N-1:0] pb [3];
    logic [N-1:0] pc [3];

    always_comb
    begin
        pa[0] = p0_x[N-1:0]; pa[1] = p0_y[N-1:0]; pa[2] = p0_z[N-1:0];
        pb[0] = p1_x[N-1:0]; pb[1] = p1_y[N-1:0]; pb[2] = p1_z[N-1:0];
        pc[0] = p2_x[N-1:0]; pc[1] = p2_y[N-1:0]; pc[2] = p2_z[N-1:0];
    end

    // valid bits, stage 1 .. 8
    logic [7:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:0], accept};
        end
    end

    // stage 1: edges e1 = p1 - p0, e2 = p2 - p0, exact
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [EW-1:0] e1_reg  [3];
    logic signed [EW-1:0] e2_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_next[k] = {pb[k][N-1], pb[k]} - {pa[k][N-1], pa[k]};
            e2_next[k] = {pc[k][N-1], pc[k]} - {pa[k][N-1], pa[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg <= e1_next;
        e2_reg <= e2_next;
    end

    // stage 2: the edge products of c = e2 x e1
    logic signed [PW-1:0] prod_next [6];
    logic signed [PW-1:0] prod_reg  [6];

    always_comb
    begin
        prod_next[0] = e2_reg[1] * e1_reg[2];
        prod_next[1] = e2_reg[2] * e1_reg[1];
        prod_next[2] = e2_reg[2] * e1_reg[0];
        prod_next[3] = e2_reg[0] * e1_reg[2];
        prod_next[4] = e2_reg[0] * e1_reg[1];
        prod_next[5] = e2_reg[1] * e1_reg[0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // stage 3: cross components
    logic signed [CW-1:0] c_next [3];
    logic signed [CW-1:0] c_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_next[k] = CW'(prod_reg[2*k]) - CW'(prod_reg[2*k+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    // stage 4: sign and magnitude
    logic [CW-1:0]  cabs [3];
    logic [MW-1:0]  mag_next [3];
    logic [MW-1:0]  mag_reg  [3];
    logic [2:0]     neg_next;
    logic [2:0]     neg_reg [5];          // stages 4 .. 8

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg_next[k] = c_reg[k][CW-1];
            cabs[k]     = neg_next[k] ? CW'(-c_reg[k]) : CW'(c_reg[k]);
            mag_next[k] = cabs[k][MW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg[0] <= neg_next;
        for (int s = 1; s < 5; s++)
        begin
            neg_reg[s] <= neg_reg[s-1];
        end
    end

    // stage 5: limb partial products of |c|^2
    logic [MP-1:0]    mpad [3];
    logic [2*LB-1:0]  pp_next [3][NL][NL];
    logic [2*LB-1:0]  pp_reg  [3][NL][NL];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mpad[k] = MP'(mag_reg[k]);
            for (int i = 0; i < NL; i++)
            begin
                for (int j = 0; j < NL; j++)
                begin
                    pp_next[k][i][j] = mpad[k][i*LB +: LB] * mpad[k][j*LB +: LB];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= pp_next;
    end

    // stage 6: row sums
    logic [SQP-1:0] row_next [3][NL];
    logic [SQP-1:0] row_reg  [3][NL];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < NL; i++)
            begin
                row_next[k][i] = '0;
                for (int j = 0; j < NL; j++)
                begin
                    row_next[k][i] = row_next[k][i] + (SQP'(pp_reg[k][i][j]) << (LB * j));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    // stage 7: squares
    logic [SQP-1:0] sqf  [3];
    logic [SQW-1:0] sq_next [3];
    logic [SQW-1:0] sq_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sqf[k] = '0;
            for (int i = 0; i < NL; i++)
            begin
                sqf[k] = sqf[k] + (row_reg[k][i] << (LB * i));
            end
            sq_next[k] = sqf[k][SQW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    // stage 8: squared length; squares travel alongside
    logic [SW-1:0]  s_next;
    logic [SW-1:0]  s_reg;
    logic [SQW-1:0] sq8_reg [3];

    assign s_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        sq8_reg <= sq_reg;
    end

    // scaling lanes, one per component
    logic                             degen8;
    tfn_pkg::tag_t                    ltag_in  [3];
    tfn_pkg::tag_t                    ltag_out [3];
    logic signed [tfn_pkg::OUT_W-1:0] lnorm    [3];

    assign degen8 = (s_reg == '0);

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign ltag_in[k].valid = v_reg[7];
        assign ltag_in[k].neg   = neg_reg[4][k];
        assign ltag_in[k].degen = degen8;

        tfn_lane #(
            .NUM_W     (SQW),
            .DEN_W     (SW),
            .FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_tag  (ltag_in[k]),
            .num     (sq8_reg[k]),
            .den     (s_reg),
            .out_tag (ltag_out[k]),
            .normal  (lnorm[k])
        );
    end

    assign normal_x   = lnorm[0];
    assign normal_y   = lnorm[1];
    assign normal_z   = lnorm[2];
    assign done       = ltag_out[0].valid;
    assign degenerate = ltag_out[0].degen;

    // checks
    `TFN_ASSERT_DLY(a_latency, accept, LAT, done, "item did not emerge after fixed latency")
    `TFN_ASSERT_IMP(a_degen_zero, done && degenerate,
        normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate result not zero")
    `TFN_ASSERT_IMP(a_unit_nonzero, done && !degenerate,
        normal_x != '0 || normal_y != '0 || normal_z != '0, "non-degenerate normal is zero")
    `TFN_ASSERT_IMP(a_lanes_aligned, ltag_out[0].valid || ltag_out[1].valid || ltag_out[2].valid,
        ltag_out[0].valid && ltag_out[1].valid && ltag_out[2].valid, "lanes out of step")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal core testbench
// Directed rows and random triangles go in through start/busy. Each result
// strobed by done is checked against its row or an exact unit-normal model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NUM_RANDOM   = 800;
    localparam int DRAIN_CYCLES = 130;
    localparam int MAX_GAP      = 14;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               degen;
    } normal_t;

    typedef struct {
        logic signed [31:0] p [9];
        bit                 typed;   // expected result given in the row
        normal_t            want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] p0_x = '0, p0_y = '0, p0_z = '0;
    logic signed [31:0] p1_x = '0, p1_y = '0, p1_z = '0;
    logic signed [31:0] p2_x = '0, p2_y = '0, p2_z = '0;
    logic done;
    logic signed [31:0] normal_x, normal_y, normal_z;
    logic degenerate;

    normal_t pending_normals [$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_degen = 0;
    int      n_sent = 0;

    always #4 clk = ~clk;

    triangle_face_normal_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .p0_x       (p0_x),
        .p0_y       (p0_y),
        .p0_z       (p0_z),
        .p1_x       (p1_x),
        .p1_y       (p1_y),
        .p1_z       (p1_z),
        .p2_x       (p2_x),
        .p2_y       (p2_y),
        .p2_z       (p2_z),
        .done       (done),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .degenerate (degenerate)
    );

    // Exact unit normal: c = e2 x e1, each component rounded to nearest
    // (ties away from zero) by a binary search on squared integers.
    function automatic normal_t face_normal(input logic signed [31:0] p [9]);
        logic signed [32:0] ax, ay, az, bx, by, bz;
        logic signed [66:0] cr [3];
        logic        [66:0] m67;
        bit [255:0] mg [3];
        bit [255:0] len2, rhs, lhs, d;
        longint unsigned lo, hi, mid;
        logic [31:0] q [3];
        normal_t r;
        ax = p[3] - p[0];
        ay = p[4] - p[1];
        az = p[5] - p[2];
        bx = p[6] - p[0];
        by = p[7] - p[1];
        bz = p[8] - p[2];
        cr[0] = by * az - bz * ay;
        cr[1] = bz * ax - bx * az;
        cr[2] = bx * ay - by * ax;
        for (int i = 0; i < 3; i++)
        begin
            m67 = (cr[i] < 0) ? -cr[i] : cr[i];
            mg[i] = m67;
        end
        len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        if (len2 == 0)
        begin
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            rhs = (mg[i] * mg[i]) << 62;
            lo = 0;
            hi = 64'd1 << 30;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                d = 2 * mid - 1;
                lhs = d * d * len2;
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            q[i] = lo[31:0];
            if (cr[i] < 0)
                q[i] = -q[i];
        end
        r.nx = q[0];
        r.ny = q[1];
        r.nz = q[2];
        r.degen = 1'b0;
        return r;
    endfunction

    // Present one item at the falling edge, hold until accepted.
    task automatic send_triangle(input logic signed [31:0] p [9], input bit typed,
                                 input normal_t want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        {p0_x, p0_y, p0_z} <= {p[0], p[1], p[2]};
        {p1_x, p1_y, p1_z} <= {p[3], p[4], p[5]};
        {p2_x, p2_y, p2_z} <= {p[6], p[7], p[8]};
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_normals.push_back(typed ? want : face_normal(p));
        n_sent++;
    endtask

    // Result checker: done is a one-cycle strobe, sampled at the rising edge.
    always @(posedge clk)
    begin
        normal_t w;
        if (rst_n && done)
        begin
            if (pending_normals.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: %0d %0d %0d degen %0b",
                             normal_x, normal_y, normal_z, degenerate);
            end
            else
            begin
                w = pending_normals.pop_front();
                n_checked++;
                if (w.degen)
                    n_degen++;
                if (normal_x !== w.nx || normal_y !== w.ny || normal_z !== w.nz ||
                    degenerate !== w.degen)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("normal mismatch: got %0d %0d %0d d%0b, want %0d %0d %0d d%0b",
                                 normal_x, normal_y, normal_z, degenerate,
                                 w.nx, w.ny, w.nz, w.degen);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_coord(input int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            3: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    initial
    begin
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
        localparam logic signed [31:0] MINC = 32'sh8000_0000;
        row_t rows [$];
        row_t rw;
        normal_t zero_n;
        logic signed [31:0] pt [9];
        int kind, k;

        zero_n = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
        // all corners equal: degenerate
        rw.p = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; rw.typed = 1; rw.want = zero_n;
        rows.push_back(rw);
        // extremes, all corners equal
        rw.p = '{MAXC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MAXC};
        rows.push_back(rw);
        // collinear corners
        rw.p = '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE};
        rows.push_back(rw);
        // unit triangles in the coordinate planes
        rw.p = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0}; rw.typed = 1;
        rw.want = '{nx: 0, ny: 0, nz: -(32'sd1 <<< 30), degen: 1'b0};
        rows.push_back(rw);
        rw.p = '{0, 0, 0, 0, ONE, 0, ONE, 0, 0};
        rw.want = '{nx: 0, ny: 0, nz: (32'sd1 <<< 30), degen: 1'b0};
        rows.push_back(rw);
        rw.p = '{0, 0, 0, 0, ONE, 0, 0, 0, ONE};
        rw.want = '{nx: -(32'sd1 <<< 30), ny: 0, nz: 0, degen: 1'b0};
        rows.push_back(rw);
        rw.p = '{0, 0, 0, 0, 0, ONE, ONE, 0, 0};
        rw.want = '{nx: 0, ny: -(32'sd1 <<< 30), nz: 0, degen: 1'b0};
        rows.push_back(rw);
        // everything else goes through the predictor
        rw.typed = 0;
        rw.p = '{0, 0, 0, 3, 0, 0, 0, 0, 4}; rows.push_back(rw);
        rw.p = '{1, 1, 1, 2, 2, 1, 1, 2, 2}; rows.push_back(rw);
        rw.p = '{0, 0, 0, 1, 0, 0, 0, 1, 1}; rows.push_back(rw);
        rw.p = '{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC}; rows.push_back(rw);
        rw.p = '{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC}; rows.push_back(rw);
        rw.p = '{MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC}; rows.push_back(rw);
        rw.p = '{MAXC, MINC, 0, MINC, MAXC, MAXC, MINC, MINC, MINC}; rows.push_back(rw);
        rw.p = '{-1, -1, -1, 0, 0, 0, 1, -1, 0}; rows.push_back(rw);
        rw.p = '{0, 0, 0, 1, 2, 3, 4, 5, 7}; rows.push_back(rw);
        rw.p = '{0, 0, 0, 1, 1, 0, 1, 0, 1}; rows.push_back(rw);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_triangle(rows[i].p, rows[i].typed, rows[i].want);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            kind = $urandom_range(0, 4);
            for (int j = 0; j < 9; j++)
                pt[j] = rand_coord(kind);
            // some collinear or repeated corners
            if ($urandom_range(0, 9) == 0)
            begin
                k = $signed($urandom_range(0, 6)) - 3;
                for (int j = 0; j < 3; j++)
                begin
                    pt[3 + j] = rand_coord(4);
                    pt[6 + j] = pt[j] + k * (pt[3 + j] - pt[j]);
                end
            end
            send_triangle(pt, 0, zero_n);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        n_errors += pending_normals.size();
        $display("sent %0d triangles (%0d directed), checked %0d normals, %0d degenerate",
                 n_sent, rows.size(), n_checked, n_degen);
        if (n_errors == 0)
            $display("triangle_face_normal_core: match");
        else
            $display("triangle_face_normal_core: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("triangle_face_normal_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
